// File: design/cdpf_pkg.sv
package cdpf_pkg;

  localparam int RANGES     = 16;
  localparam int ENTRY_W    = (RANGES > 1) ? $clog2(RANGES) : 1;
  localparam int CNT_W      = $clog2(RANGES + 1);
  localparam int WORDS      = 4;
  localparam int ADDR_DEPTH = RANGES * WORDS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic FAM_V4 = 1'b0;
  localparam logic FAM_V6 = 1'b1;

  localparam logic [5:0] POS_MAX      = 6'd63;
  localparam logic [5:0] ETH_OFF      = 6'd12;
  localparam logic [5:0] VLAN_ETH_OFF = 6'd16;
  localparam logic [5:0] BASE_PLAIN   = 6'd14;
  localparam logic [5:0] BASE_VLAN    = 6'd18;
  localparam logic [5:0] V4_DST_OFF   = 6'd16;
  localparam logic [5:0] V6_DST_OFF   = 6'd24;
  localparam logic [5:0] V4_DST_LEN   = 6'd4;
  localparam logic [5:0] V6_DST_LEN   = 6'd16;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_V4   = 16'h0800;
  localparam logic [15:0] TYPE_V6   = 16'h86DD;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_V4,
    KIND_V6
  } kind_t;

  // lookup job handed from parser to scanner
  typedef struct packed {
    kind_t                  kind;
    logic [WORDS-1:0][31:0] dest;
  } job_t;

  // per-entry attributes, one RAM word
  typedef struct packed {
    logic        family;
    logic [7:0]  prefix;
    logic [31:0] mask;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] entry;
    logic [1:0]         word;
    logic [31:0]        addr;
    entry_t             attr;
  } tbl_wr_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [1:0]         word;
  } tbl_rd_t;

  typedef struct packed {
    logic scanning;
  } back_stat_t;

  // mask of one 32-bit word of an IPv6 prefix, word 0 most significant
  function automatic logic [31:0] prefix_word_mask(input logic [7:0] prefix,
                                                   input logic [1:0] w);
    logic [8:0] lo;
    logic [8:0] sh;
    logic [31:0] m;
    lo = {2'b00, w, 5'b00000};
    sh = lo + 9'd32 - {1'b0, prefix};
    if ({1'b0, prefix} <= lo) begin
      m = '0;
    end else if ({1'b0, prefix} >= lo + 9'd32) begin
      m = ALL_ONES;
    end else begin
      m = ALL_ONES << sh[4:0];
    end
    return m;
  endfunction

endpackage

// File: design/cdpf_ram.sv
module cdpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cdpf_front.sv
module cdpf_front import cdpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  entry_index,
  input  logic        entry_family,
  input  logic [1:0]  word_select,
  input  logic [31:0] addr_word,
  input  logic [31:0] v4_mask,
  input  logic [7:0]  v6_prefix,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  input  logic        q_full,
  input  logic        q_empty,
  input  back_stat_t  bk_stat,
  output logic        q_push,
  output job_t        q_job,
  output tbl_wr_t     tbl_wr
);

  logic [5:0]             pos;
  logic                   vlan;
  logic [15:0]            etype;
  logic [WORDS-1:0][31:0] dest;

  logic [5:0]             pos_next;
  logic                   vlan_next;
  logic [15:0]            etype_next;
  logic [WORDS-1:0][31:0] dest_next;
  logic [5:0]             base;
  logic [5:0]             off;
  logic [5:0]             v6_off;
  logic                   fire;
  kind_t                  kind;

  // loads wait until no lookup is pending so a frame sees the table as of its last beat
  assign in_ready = (operation == OP_FRAME) ? (!frame_last || !q_full)
                                            : (q_empty && !bk_stat.scanning);
  assign fire = in_valid && in_ready;

  always_comb begin
    etype_next = etype;
    vlan_next  = vlan;
    if (pos == ETH_OFF) begin
      etype_next = {frame_byte, 8'h00};
    end else if (pos == ETH_OFF + 6'd1) begin
      etype_next = {etype[15:8], frame_byte};
      vlan_next  = ({etype[15:8], frame_byte} == TYPE_VLAN);
    end else if (vlan && pos == VLAN_ETH_OFF) begin
      etype_next = {frame_byte, 8'h00};
    end else if (vlan && pos == VLAN_ETH_OFF + 6'd1) begin
      etype_next = {etype[15:8], frame_byte};
    end

    base   = vlan_next ? BASE_VLAN : BASE_PLAIN;
    off    = pos - base;   // wraps high before the payload, outside both windows
    v6_off = off - V6_DST_OFF;

    dest_next = dest;
    if (etype_next == TYPE_V4 && off >= V4_DST_OFF && off < V4_DST_OFF + V4_DST_LEN) begin
      dest_next[0] = {dest[0][23:0], frame_byte};
    end
    if (etype_next == TYPE_V6 && off >= V6_DST_OFF && off < V6_DST_OFF + V6_DST_LEN) begin
      dest_next[v6_off[3:2]] = {dest[v6_off[3:2]][23:0], frame_byte};
    end

    pos_next = (pos == POS_MAX) ? POS_MAX : pos + 6'd1;

    if (etype_next == TYPE_V4 && pos_next >= base + V4_DST_OFF + V4_DST_LEN) begin
      kind = KIND_V4;
    end else if (etype_next == TYPE_V6 && pos_next >= base + V6_DST_OFF + V6_DST_LEN) begin
      kind = KIND_V6;
    end else begin
      kind = KIND_REJECT;
    end
  end

  assign q_push     = fire && operation == OP_FRAME && frame_last;
  assign q_job.kind = kind;
  assign q_job.dest = dest_next;

  assign tbl_wr.en          = fire && operation == OP_LOAD && (32'(entry_index) < RANGES);
  assign tbl_wr.entry       = ENTRY_W'(entry_index);
  assign tbl_wr.word        = word_select;
  assign tbl_wr.addr        = addr_word;
  assign tbl_wr.attr.family = entry_family;
  assign tbl_wr.attr.prefix = v6_prefix;
  assign tbl_wr.attr.mask   = v4_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      vlan  <= 1'b0;
      etype <= '0;
      dest  <= '0;
    end else if (fire && operation == OP_FRAME) begin
      if (frame_last) begin
        pos   <= '0;
        vlan  <= 1'b0;
        etype <= '0;
        dest  <= '0;
      end else begin
        pos   <= pos_next;
        vlan  <= vlan_next;
        etype <= etype_next;
        dest  <= dest_next;
      end
    end
  end

endmodule

// File: design/cdpf_queue.sv
module cdpf_queue import cdpf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

// File: design/cdpf_back.sv
module cdpf_back import cdpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  used_ranges,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        q_pop,
  output tbl_rd_t     tbl_rd,
  input  logic [31:0] addr_rdata,
  input  entry_t      ent_rdata,
  output back_stat_t  bk_stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accept
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state;
  kind_t                  job_kind;
  logic [WORDS-1:0][31:0] job_dest;
  logic [CNT_W-1:0]       n_reg;
  logic [CNT_W-1:0]       ei;
  logic [1:0]             wi;
  logic                   issuing;
  logic                   rd_valid;
  logic [1:0]             rd_word;
  logic                   run;
  logic                   hit;

  logic [CNT_W-1:0] n_eff;
  logic [31:0]      cur_mask;
  logic [31:0]      cur_dest;
  logic             match;
  logic             run_now;
  logic             hit_now;
  logic             last_issue;

  assign n_eff = (32'(used_ranges) > RANGES) ? CNT_W'(RANGES) : CNT_W'(used_ranges);

  assign q_pop            = (state == S_IDLE) && !q_empty;
  assign tbl_rd.entry     = ei[ENTRY_W-1:0];
  assign tbl_rd.word      = wi;
  assign bk_stat.scanning = (state == S_SCAN);

  assign last_issue = (ei + CNT_W'(1) == n_reg) && (job_kind == KIND_V4 || wi == 2'd3);

  always_comb begin
    cur_mask = (job_kind == KIND_V6) ? prefix_word_mask(ent_rdata.prefix, rd_word)
                                     : ent_rdata.mask;
    cur_dest = job_dest[rd_word];
    match    = ((cur_dest ^ addr_rdata) & cur_mask) == '0;
    run_now  = (rd_word == 2'd0 || run) && match;
    if (job_kind == KIND_V6) begin
      hit_now = ent_rdata.family == FAM_V6 && rd_word == 2'd3 && run_now;
    end else begin
      hit_now = ent_rdata.family == FAM_V4 && match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        accept    <= hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job_kind <= q_head.kind;
            job_dest <= q_head.dest;
            n_reg    <= n_eff;
            ei       <= '0;
            wi       <= '0;
            hit      <= 1'b0;
            if (q_head.kind == KIND_REJECT || n_eff == '0) begin
              state <= S_DONE;
            end else begin
              issuing <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read issued this beat, compared the next
          rd_valid <= issuing;
          rd_word  <= wi;
          if (issuing) begin
            if (last_issue) begin
              issuing <= 1'b0;
            end
            if (job_kind == KIND_V6 && wi != 2'd3) begin
              wi <= wi + 2'd1;
            end else begin
              wi <= 2'd0;
              ei <= ei + CNT_W'(1);
            end
          end
          if (rd_valid) begin
            run <= run_now;
            if (hit_now) begin
              hit <= 1'b1;
            end
          end
          if (!issuing && !rd_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/cidr_destination_packet_filter.sv
// Frame beats are taken one per cycle, but a last beat waits while the lookup queue is full;
// a load beat is taken once no lookup is pending. The result of an IPv4 or IPv6 frame follows
// a scan of the N entries in use (four words each for IPv6), one word at a time through the
// single read port of the address RAM; other frames give their result without a scan.
// The next frame's bytes stream in while the table scan runs (two lookups may queue).
// rst is synchronous; it clears the parser, queue, scanner and entry count, not the table.
module cidr_destination_packet_filter import cdpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  entry_index,
  input  logic        entry_family,
  input  logic [1:0]  word_select,
  input  logic [31:0] addr_word,
  input  logic [31:0] v4_mask,
  input  logic [7:0]  v6_prefix,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accept
);

  logic [4:0]  used_ranges;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  job_t        q_job;
  job_t        q_head;
  tbl_wr_t     tbl_wr;
  tbl_rd_t     tbl_rd;
  back_stat_t  bk_stat;
  logic [31:0] addr_rdata;
  entry_t      ent_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_ranges <= '0;
    end else if (cfg_we) begin
      used_ranges <= cfg_wdata;
    end
  end

  cdpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .entry_index  (entry_index),
    .entry_family (entry_family),
    .word_select  (word_select),
    .addr_word    (addr_word),
    .v4_mask      (v4_mask),
    .v6_prefix    (v6_prefix),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last),
    .q_full       (q_full),
    .q_empty      (q_empty),
    .bk_stat      (bk_stat),
    .q_push       (q_push),
    .q_job        (q_job),
    .tbl_wr       (tbl_wr)
  );

  cdpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  cdpf_ram #(
    .WIDTH (32),
    .DEPTH (ADDR_DEPTH)
  ) u_addr_ram (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr ({tbl_wr.entry, tbl_wr.word}),
    .wdata (tbl_wr.addr),
    .raddr ({tbl_rd.entry, tbl_rd.word}),
    .rdata (addr_rdata)
  );

  cdpf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RANGES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.entry),
    .wdata (tbl_wr.attr),
    .raddr (tbl_rd.entry),
    .rdata (ent_rdata)
  );

  cdpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .used_ranges (used_ranges),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .tbl_rd      (tbl_rd),
    .addr_rdata  (addr_rdata),
    .ent_rdata   (ent_rdata),
    .bk_stat     (bk_stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accept      (accept)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("lookup queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("lookup queue underflow");

  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (!bk_stat.scanning && q_empty))
    else $error("table written while a lookup is pending");

endmodule

// File: tb/sv/cidr_destination_packet_filter_tb.sv
`timescale 1ns / 100ps

module cidr_destination_packet_filter_tb import cdpf_pkg::*;;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 100;
  localparam int N_PHASES     = 2;

  typedef enum int {FK_V4, FK_V6, FK_OTHER, FK_QINQ} frame_kind_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    logic        fam;
    logic [1:0]  wsel;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [7:0]  pfx;
    logic [7:0]  fbyte;
    logic        flast;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [3:0]  entry_index = '0;
  logic        entry_family = 1'b0;
  logic [1:0]  word_select = '0;
  logic [31:0] addr_word = '0;
  logic [31:0] v4_mask = '0;
  logic [7:0]  v6_prefix = '0;
  logic [7:0]  frame_byte = '0;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accept;

  cidr_destination_packet_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .entry_index  (entry_index),
    .entry_family (entry_family),
    .word_select  (word_select),
    .addr_word    (addr_word),
    .v4_mask      (v4_mask),
    .v6_prefix    (v6_prefix),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accept       (accept)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted filter state
  logic [31:0] t_addr [RANGES][WORDS];
  logic [31:0] t_mask [RANGES];
  logic [7:0]  t_pfx  [RANGES];
  logic        t_fam  [RANGES];
  logic [4:0]  used_ranges_q = '0;
  logic [5:0]  rx_pos = '0;
  logic        rx_vlan = 1'b0;
  logic [15:0] rx_type = '0;
  logic [31:0] rx_dst [WORDS];

  // stimulus-side copy of the table, used to aim destinations at entries
  logic [31:0] gen_addr [RANGES][WORDS];
  logic        gen_fam  [RANGES];

  beat_t beat_q [$];
  logic  accept_q [$];
  beat_t cur_beat;
  int    n_errors = 0;
  int    n_beats = 0;
  int    n_frames = 0;
  int    src_gap = 0;
  int    snk_wait = 0;
  int    hold_cnt = 0;
  bit    hold_arm = 1'b0;
  bit    src_idle_en = 1'b1;
  bit    snk_idle_en = 1'b1;

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic frame_verdict();
    int i;
    int bi;
    int n;
    logic [31:0]  m4;
    logic [127:0] m6;
    logic [127:0] d6;
    logic [127:0] a6;
    bi = rx_vlan ? BASE_VLAN : BASE_PLAIN;
    n = (used_ranges_q > RANGES) ? RANGES : used_ranges_q;
    if (rx_type == TYPE_V4) begin
      if (rx_pos < bi + V4_DST_OFF + V4_DST_LEN) return 1'b0;
      for (i = 0; i < n; i++) begin
        m4 = t_mask[i];
        if (t_fam[i] == FAM_V4 && (rx_dst[0] & m4) == (t_addr[i][0] & m4)) return 1'b1;
      end
    end else if (rx_type == TYPE_V6) begin
      if (rx_pos < bi + V6_DST_OFF + V6_DST_LEN) return 1'b0;
      d6 = {rx_dst[0], rx_dst[1], rx_dst[2], rx_dst[3]};
      for (i = 0; i < n; i++) begin
        if (t_fam[i] == FAM_V6) begin
          // prefix of 128 or more keeps every bit
          m6 = (t_pfx[i] >= 8'd128) ? {128{1'b1}} : ~({128{1'b1}} >> t_pfx[i]);
          a6 = {t_addr[i][0], t_addr[i][1], t_addr[i][2], t_addr[i][3]};
          if ((d6 & m6) == (a6 & m6)) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic filter_beat(input beat_t b);
    int p;
    int bi;
    int k;
    if (b.op == OP_LOAD) begin
      t_addr[b.idx][b.wsel] = b.addr;
      t_fam[b.idx]  = b.fam;
      t_mask[b.idx] = b.mask;
      t_pfx[b.idx]  = b.pfx;
    end else begin
      p = rx_pos;
      if (p == ETH_OFF) begin
        rx_type = {b.fbyte, 8'h00};
      end else if (p == ETH_OFF + 1) begin
        rx_type[7:0] = b.fbyte;
        rx_vlan = (rx_type == TYPE_VLAN);
      end else if (rx_vlan && p == VLAN_ETH_OFF) begin
        rx_type = {b.fbyte, 8'h00};
      end else if (rx_vlan && p == VLAN_ETH_OFF + 1) begin
        rx_type[7:0] = b.fbyte;
      end
      bi = rx_vlan ? BASE_VLAN : BASE_PLAIN;
      if (rx_type == TYPE_V4 && p >= bi + V4_DST_OFF && p < bi + V4_DST_OFF + V4_DST_LEN)
        rx_dst[0] = {rx_dst[0][23:0], b.fbyte};
      if (rx_type == TYPE_V6 && p >= bi + V6_DST_OFF && p < bi + V6_DST_OFF + V6_DST_LEN) begin
        k = (p - bi - V6_DST_OFF) >> 2;
        rx_dst[k] = {rx_dst[k][23:0], b.fbyte};
      end
      rx_pos = (rx_pos < POS_MAX) ? rx_pos + 6'd1 : POS_MAX;
      if (b.flast) begin
        accept_q.push_back(frame_verdict());
        rx_pos = '0;
        rx_vlan = 1'b0;
        rx_type = '0;
        for (k = 0; k < WORDS; k++) rx_dst[k] = '0;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) filter_beat(cur_beat);
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        cur_beat = beat_q.pop_front();
        operation    <= cur_beat.op;
        entry_index  <= cur_beat.idx;
        entry_family <= cur_beat.fam;
        word_select  <= cur_beat.wsel;
        addr_word    <= cur_beat.addr;
        v4_mask      <= cur_beat.mask;
        v6_prefix    <= cur_beat.pfx;
        frame_byte   <= cur_beat.fbyte;
        frame_last   <= cur_beat.flast;
        in_valid     <= 1'b1;
        src_gap = src_idle_en ? $urandom_range(0, 11) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      snk_wait = 0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else if (hold_arm) begin
      hold_arm = 1'b0;
      hold_cnt = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) snk_wait = snk_idle_en ? $urandom_range(0, 11) : 0;
      if (snk_wait > 0) begin
        snk_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (accept_q.size() == 0) begin
        report_err("result beat with no frame outstanding");
      end else begin
        want = accept_q.pop_front();
        if (accept !== want)
          report_err($sformatf("accept %b, expected %b", accept, want));
      end
    end
  end

  function automatic beat_t rand_beat();
    beat_t b;
    b.op    = $urandom;
    b.idx   = $urandom;
    b.fam   = $urandom;
    b.wsel  = $urandom;
    b.addr  = $urandom;
    b.mask  = $urandom;
    b.pfx   = $urandom;
    b.fbyte = $urandom;
    b.flast = $urandom;
    return b;
  endfunction

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONES;
      5:       return $urandom;
      default: return ~(ALL_ONES >> $urandom_range(0, 32));
    endcase
  endfunction

  function automatic logic [7:0] rand_pfx();
    if ($urandom_range(0, 5) == 0) return $urandom_range(129, 255);
    return $urandom_range(0, 128);
  endfunction

  task automatic queue_load(input int idx, input logic fam, input int wsel,
                            input logic [31:0] addr, input logic [31:0] mask,
                            input logic [7:0] pfx);
    beat_t b;
    b = rand_beat();
    b.op   = OP_LOAD;
    b.idx  = idx;
    b.fam  = fam;
    b.wsel = wsel;
    b.addr = addr;
    b.mask = mask;
    b.pfx  = pfx;
    gen_addr[idx][wsel] = addr;
    gen_fam[idx] = fam;
    beat_q.push_back(b);
    n_beats++;
  endtask

  task automatic queue_entry(input int idx, input logic fam, input logic [127:0] addr,
                             input logic [31:0] mask, input logic [7:0] pfx);
    int s;
    int j;
    int w;
    s = $urandom_range(0, 3);
    for (j = 0; j < WORDS; j++) begin
      w = (s + j) % WORDS;
      queue_load(idx, fam, w, addr[127 - 32 * w -: 32], mask, pfx);
    end
  endtask

  task automatic queue_rand_entry(input int idx);
    queue_entry(idx, $urandom, {$urandom, $urandom, $urandom, $urandom}, rand_mask(),
                rand_pfx());
  endtask

  task automatic queue_frame(input frame_kind_t kind, input bit vtag, input int len,
                             input logic [127:0] dst, input bit mid_load);
    logic [7:0]  fb [];
    logic [15:0] et;
    beat_t       b;
    int          base;
    int          i;
    int          load_at;
    fb = new[len];
    for (i = 0; i < len; i++) fb[i] = $urandom;
    if (kind == FK_QINQ) vtag = 1'b1;
    case (kind)
      FK_V4:   et = TYPE_V4;
      FK_V6:   et = TYPE_V6;
      FK_QINQ: et = TYPE_VLAN;
      default: begin
        et = $urandom;
        if (et == TYPE_V4 || et == TYPE_V6 || et == TYPE_VLAN) et = et ^ 16'h0001;
      end
    endcase
    base = vtag ? BASE_VLAN : BASE_PLAIN;
    if (vtag) begin
      if (len > 12) fb[12] = TYPE_VLAN[15:8];
      if (len > 13) fb[13] = TYPE_VLAN[7:0];
      if (len > 16) fb[16] = et[15:8];
      if (len > 17) fb[17] = et[7:0];
    end else begin
      if (len > 12) fb[12] = et[15:8];
      if (len > 13) fb[13] = et[7:0];
    end
    if (kind == FK_V4) begin
      for (i = 0; i < 4; i++)
        if (base + V4_DST_OFF + i < len) fb[base + V4_DST_OFF + i] = dst[127 - 8 * i -: 8];
    end else if (kind == FK_V6) begin
      for (i = 0; i < 16; i++)
        if (base + V6_DST_OFF + i < len) fb[base + V6_DST_OFF + i] = dst[127 - 8 * i -: 8];
    end
    load_at = mid_load ? $urandom_range(0, len - 1) : -1;
    for (i = 0; i < len; i++) begin
      // table rewrite ahead of a randomly chosen beat of the frame
      if (i == load_at)
        queue_load($urandom_range(0, RANGES - 1), $urandom, $urandom_range(0, 3), $urandom,
                   rand_mask(), rand_pfx());
      b = rand_beat();
      b.op    = OP_FRAME;
      b.fbyte = fb[i];
      b.flast = (i == len - 1);
      beat_q.push_back(b);
      n_beats++;
    end
    n_frames++;
  endtask

  function automatic logic [127:0] pick_dst(input frame_kind_t kind);
    logic [127:0] d;
    int r;
    int e;
    int bit_no;
    d = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 3);
    if (r != 0) begin
      e = $urandom_range(0, RANGES - 1);
      d = {gen_addr[e][0], gen_addr[e][1], gen_addr[e][2], gen_addr[e][3]};
      if (r == 3) begin
        bit_no = (kind == FK_V4) ? 96 + $urandom_range(0, 31) : $urandom_range(0, 127);
        d[bit_no] = ~d[bit_no];
      end
    end
    return d;
  endfunction

  task automatic queue_rand_frame();
    frame_kind_t kind;
    bit vtag;
    int r;
    int need;
    int len;
    r = $urandom_range(0, 9);
    kind = (r < 4) ? FK_V4 : (r < 8) ? FK_V6 : (r == 8) ? FK_OTHER : FK_QINQ;
    vtag = ($urandom_range(0, 2) == 0) || kind == FK_QINQ;
    need = (vtag ? BASE_VLAN : BASE_PLAIN) + ((kind == FK_V6) ? 40 : 20);
    case ($urandom_range(0, 7))
      0: len = $urandom_range(0, 1) ? need - 1 : $urandom_range(1, need - 1);
      1: len = $urandom_range(64, 72);
      default: len = need + $urandom_range(0, 6);
    endcase
    queue_frame(kind, vtag, len, pick_dst(kind), $urandom_range(0, 7) == 0);
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    while (beat_q.size() != 0 || in_valid || accept_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_used_ranges(input logic [4:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    used_ranges_q = v;
    @(negedge clk);
  endtask

  initial begin
    logic [127:0] a13;
    logic [127:0] a14;
    logic [127:0] d;
    int ph;
    int e;
    int f;
    int k;
    for (k = 0; k < WORDS; k++) rx_dst[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table in use: nothing can match, nothing is read
    queue_frame(FK_V4, 1'b0, 34, {$urandom, 96'h0}, 1'b0);
    queue_frame(FK_OTHER, 1'b0, 1, '0, 1'b0);
    queue_frame(FK_V6, 1'b1, 58, {$urandom, $urandom, $urandom, $urandom}, 1'b0);
    wait_idle(SETTLE);

    // fill every entry before any nonzero count
    for (e = 0; e < 12; e++) queue_rand_entry(e);
    a13 = {$urandom, $urandom, $urandom, $urandom};
    a14 = {$urandom, $urandom, $urandom, $urandom};
    queue_entry(12, FAM_V4, {ALL_ONES, 96'h0}, ALL_ONES, 8'd0);
    queue_entry(13, FAM_V6, a13, '0, 8'd128);
    queue_entry(14, FAM_V6, a14, ALL_ONES, 8'd255);
    queue_entry(15, FAM_V4, {$urandom, 96'h0}, '0, 8'd0);
    wait_idle(SETTLE);

    write_used_ranges(5'd16);
    // back-to-back frames against a stalled output fill the lookup queue
    src_idle_en = 1'b0;
    hold_arm = 1'b1;
    queue_frame(FK_V4, 1'b0, 34, {ALL_ONES, 96'h0}, 1'b0);
    d = {gen_addr[0][0], gen_addr[0][1], gen_addr[0][2], gen_addr[0][3]};
    queue_frame(FK_V4, 1'b1, 38, d, 1'b0);
    queue_frame(FK_V6, 1'b0, 54, a13, 1'b0);
    queue_frame(FK_V6, 1'b1, 58, a13 ^ 128'h1, 1'b0);
    queue_frame(FK_V6, 1'b0, 56, a14, 1'b0);
    queue_frame(FK_V4, 1'b0, 33, {ALL_ONES, 96'h0}, 1'b0);
    queue_frame(FK_V6, 1'b0, 53, a13, 1'b0);
    queue_frame(FK_QINQ, 1'b1, 60, '0, 1'b0);
    queue_frame(FK_OTHER, 1'b0, 40, '0, 1'b0);
    queue_frame(FK_V4, 1'b1, 72, {$urandom, 96'h0}, 1'b0);
    queue_frame(FK_V6, 1'b0, 70, a14, 1'b1);
    wait_idle(SETTLE);
    src_idle_en = 1'b1;

    // count above the table size saturates
    write_used_ranges(5'd31);
    queue_frame(FK_V4, 1'b0, 36, {$urandom, 96'h0}, 1'b0);
    queue_frame(FK_V6, 1'b0, 54, a13, 1'b0);
    wait_idle(SETTLE);

    write_used_ranges(5'd1);
    queue_frame(FK_V4, 1'b0, 34, {ALL_ONES, 96'h0}, 1'b0);
    queue_frame(FK_V4, 1'b0, 34, d, 1'b0);
    wait_idle(SETTLE);

    ph = 0;
    while (ph < N_PHASES) begin
      case (ph % 6)
        0: write_used_ranges(5'd16);
        1: write_used_ranges($urandom_range(0, 31));
        2: write_used_ranges(5'd1);
        3: write_used_ranges(5'd31);
        4: write_used_ranges($urandom_range(12, 16));
        default: write_used_ranges($urandom_range(2, 11));
      endcase
      src_idle_en = (ph % 3) != 0;
      snk_idle_en = (ph % 4) != 1;
      for (k = $urandom_range(0, 2); k > 0; k--) queue_rand_entry($urandom_range(0, RANGES - 1));
      for (f = 0; f < 3; f++) begin
        if ($urandom_range(0, 4) == 0)
          queue_load($urandom_range(0, RANGES - 1), $urandom, $urandom_range(0, 3), $urandom,
                     rand_mask(), rand_pfx());
        queue_rand_frame();
        if (f == 1 && ph == 1) wait_idle(0);
      end
      wait_idle(SETTLE);
      ph++;
    end

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TIMEOUT: %0d results outstanding, %0d beats queued", accept_q.size(),
             beat_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
design/cdpf_pkg.sv
design/cdpf_ram.sv
design/cdpf_front.sv
design/cdpf_queue.sv
design/cdpf_back.sv
design/cidr_destination_packet_filter.sv
tb/sv/cidr_destination_packet_filter_tb.sv
